// ----- design/hnht_pkg.sv -----
package hnht_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int HANDLER_BITS_DEF = 16;
  localparam logic [63:0] HASH_MOD = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [6:0] HASH_BASE = 7'd97;
  localparam logic [5:0] HASH_FOLD = 6'd59;
  localparam logic [7:0] CHAR_OFS = 8'd31;

  typedef enum logic [2:0] {
    OP_CHAR   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_LKNAME = 3'd3,
    OP_LKHASH = 3'd4,
    OP_FINDH  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOTFND  = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  key_char;
    logic [63:0] given_hash;
    logic [15:0] handler_id;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_handler;
    logic [63:0] found_hash;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HASH1, S_HASH2, S_SCAN, S_SHIFT, S_SHWR, S_FINISH
  } fsm_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input beat
    logic hash_mul;  // stage 1 of hash update
    logic hash_add;  // stage 2 of hash update
    logic scan_rd;   // issue read at scan index, advance
    logic shift_rd;  // read entry idx+1 into the read registers
    logic shift_wr;  // write the read registers to idx, advance
    logic finish;    // commit and emit result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [2:0] op;
    logic       hid_zero;
    logic       scan_end;  // scan index reached entry count
    logic       hit;       // compare on the registered read data is a match
    logic       shift_end; // no more entries above the shift index
  } sts_t;

endpackage

// ----- design/hashed_name_handler_table_core.sv -----
// Channel  Ports                         Handshake
// input    in_beat (in_beat_t)           accepted when start && !busy
// result   out_beat (out_beat_t)         one cycle, marked by out_valid
//
// A key character passes through a registered multiply by 97, then a fold
// by 59 and the modular add, before the result is registered.
// Table operations scan stored entries one per cycle through a registered
// read; a delete then shifts each entry above the match down one place,
// each step a registered read and then the write.
// Reset clears the running hash and the entry count; stored entries need none.
// The receiver cannot stall; busy holds off the next beat.
module hashed_name_handler_table_core
  import hnht_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int HANDLER_BITS = HANDLER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each beat; the datapath holds table and hash.
  hnht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  hnht_dpath #(
    .CAPACITY     (CAPACITY),
    .HANDLER_BITS (HANDLER_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule

// ----- design/hnht_ctrl.sv -----
module hnht_ctrl
  import hnht_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_t state_r, state_nxt;
  // One pending compare is in flight during the scan.
  logic pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = 1'b0;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH1;
        end
      end
      S_HASH1: begin
        // First cycle after load decides the path.
        case (sts.op)
          OP_CHAR: begin
            cmd.hash_mul = 1'b1;
            state_nxt = S_HASH2;
          end
          OP_INSERT, OP_DELETE, OP_LKNAME, OP_LKHASH, OP_FINDH: begin
            if ((sts.op == OP_INSERT || sts.op == OP_FINDH) && sts.hid_zero) begin
              state_nxt = S_FINISH;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_HASH2: begin
        cmd.hash_add = 1'b1;
        state_nxt = S_FINISH;
      end
      S_SCAN: begin
        if (pend_r && sts.hit) begin
          state_nxt = (sts.op == OP_DELETE) ? S_SHIFT : S_FINISH;
        end else if (sts.scan_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_rd = 1'b1;
          pend_nxt = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.shift_rd = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !cmd.finish)
    else $error("finish repeated");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !busy)
    else $error("load while busy");
  a_shift_delete: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> sts.op == OP_DELETE)
    else $error("shift outside delete");
`endif

endmodule

// ----- design/hnht_dpath.sv -----
module hnht_dpath
  import hnht_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int HANDLER_BITS = HANDLER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_beat_t  in_beat,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_beat_t out_beat
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [63:0] key_mem [CAPACITY];
  logic [HANDLER_BITS-1:0] hnd_mem [CAPACITY];

  in_beat_t req_r;
  logic [63:0] run_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;      // next scan address
  logic [CW-1:0] hit_idx_r;  // address of the registered read data
  logic [63:0] rd_key_r;
  logic [HANDLER_BITS-1:0] rd_hnd_r;
  logic found_r;
  logic [63:0] prod_lo_r;
  logic [6:0] prod_hi_r;
  logic [HANDLER_BITS-1:0] hid;
  logic [63:0] search_key;
  logic hit;
  logic [70:0] prod;
  logic [64:0] s1, s2;
  logic [64:0] t1;
  logic [63:0] hnew, term;

  assign hid = HANDLER_BITS'(req_r.handler_id);
  assign search_key = (req_r.opcode == OP_LKHASH) ? req_r.given_hash : run_r;
  assign hit = (req_r.opcode == OP_FINDH) ? (rd_hnd_r == hid) : (rd_key_r == search_key);

  assign sts.op = req_r.opcode;
  assign sts.hid_zero = (hid == '0);
  assign sts.scan_end = (idx_r >= cnt_r);
  assign sts.hit = hit;
  assign sts.shift_end = (idx_r + CW'(1) >= cnt_r);

  assign prod = {7'd0, run_r} * {64'd0, HASH_BASE};
  // lo + hi*59 mod P, then add the character term mod P
  always_comb begin
    t1 = {1'b0, prod_lo_r} + 65'({prod_hi_r, 6'd0} - {6'd0, prod_hi_r} * 13'd5);
    if (t1 >= {1'b0, HASH_MOD}) s1 = t1 - {1'b0, HASH_MOD};
    else s1 = t1;
    if (req_r.key_char >= CHAR_OFS) term = {56'd0, req_r.key_char - CHAR_OFS};
    else term = HASH_MOD - {56'd0, CHAR_OFS - req_r.key_char};
    s2 = s1 + {1'b0, term};
    if (s2 >= {1'b0, HASH_MOD}) hnew = 64'(s2 - {1'b0, HASH_MOD});
    else hnew = s2[63:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_beat;
    if (cmd.hash_mul) begin
      prod_lo_r <= prod[63:0];
      prod_hi_r <= prod[70:64];
    end
    if (cmd.scan_rd) begin
      rd_key_r <= key_mem[idx_r[IW-1:0]];
      rd_hnd_r <= hnd_mem[idx_r[IW-1:0]];
      hit_idx_r <= idx_r;
    end
    // A shift step reads the entry above into the read registers, then
    // writes it down one place on the following cycle.
    if (cmd.shift_rd) begin
      rd_key_r <= key_mem[IW'(idx_r + CW'(1))];
      rd_hnd_r <= hnd_mem[IW'(idx_r + CW'(1))];
    end
    if (cmd.shift_wr) begin
      key_mem[idx_r[IW-1:0]] <= rd_key_r;
      hnd_mem[idx_r[IW-1:0]] <= rd_hnd_r;
    end
    if (cmd.finish && req_r.opcode == OP_INSERT && hid != '0) begin
      if (found_r) hnd_mem[hit_idx_r[IW-1:0]] <= hid;
      else if (cnt_r < CW'(CAPACITY)) begin
        key_mem[cnt_r[IW-1:0]] <= run_r;
        hnd_mem[cnt_r[IW-1:0]] <= hid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
      found_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cmd.load) begin
        idx_r <= '0;
        found_r <= 1'b0;
      end
      if (cmd.scan_rd) idx_r <= idx_r + CW'(1);
      // A match stops the scan; point idx at the hit for a shift.
      if (!cmd.scan_rd && !cmd.shift_wr && !cmd.load && !found_r && hit_idx_r < cnt_r &&
          idx_r == hit_idx_r + CW'(1) && hit) begin
        found_r <= 1'b1;
        idx_r <= hit_idx_r;
      end
      if (cmd.shift_wr) idx_r <= idx_r + CW'(1);
      if (cmd.hash_add) run_r <= hnew;
      if (cmd.finish) begin
        case (req_r.opcode)
          OP_CHAR: begin
            out_beat.status <= ST_DONE;
            out_beat.found_handler <= '0;
            out_beat.found_hash <= run_r;
          end
          OP_INSERT: begin
            run_r <= '0;
            out_beat.found_handler <= '0;
            out_beat.found_hash <= run_r;
            if (hid == '0) out_beat.status <= ST_IGNORED;
            else if (found_r) out_beat.status <= ST_DONE;
            else if (cnt_r >= CW'(CAPACITY)) out_beat.status <= ST_FULL;
            else begin
              out_beat.status <= ST_DONE;
              cnt_r <= cnt_r + CW'(1);
            end
          end
          OP_DELETE: begin
            run_r <= '0;
            out_beat.found_handler <= '0;
            out_beat.found_hash <= run_r;
            out_beat.status <= found_r ? ST_DONE : ST_NOTFND;
            if (found_r) cnt_r <= cnt_r - CW'(1);
          end
          OP_LKNAME, OP_LKHASH: begin
            if (req_r.opcode == OP_LKNAME) run_r <= '0;
            out_beat.found_hash <= run_r;
            out_beat.status <= found_r ? ST_DONE : ST_NOTFND;
            out_beat.found_handler <= found_r ? 16'(rd_hnd_r) : 16'd0;
          end
          OP_FINDH: begin
            out_beat.found_hash <= found_r ? rd_key_r : '1;
            out_beat.found_handler <= found_r ? 16'(hid) : 16'd0;
            if (hid == '0) out_beat.status <= ST_IGNORED;
            else out_beat.status <= found_r ? ST_DONE : ST_NOTFND;
          end
          default: begin
            out_beat.status <= ST_IGNORED;
            out_beat.found_handler <= '0;
            out_beat.found_hash <= run_r;
          end
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> $stable(cnt_r))
    else $error("count moved outside commit");
`endif

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import hnht_pkg::*;

  // Clock, reset and the block's ports.
  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_beat;
  logic      out_valid;
  out_beat_t out_beat;

  localparam int TABLE_DEPTH = CAPACITY_DEF;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  hashed_name_handler_table_core #(
    .CAPACITY(CAPACITY_DEF),
    .HANDLER_BITS(HANDLER_BITS_DEF)
  ) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow copy of the table state, advanced once per accepted beat.
  logic [63:0] name_hash;
  logic [63:0] key_mirror [TABLE_DEPTH];
  logic [15:0] hid_mirror [TABLE_DEPTH];
  int          live_entries;

  // Results expected from the block, oldest first.
  out_beat_t pending_results[$];
  bit        any_failure;
  longint unsigned cycle_count;

  // Modular arithmetic over P = 2^64 - 59, done at full width.
  function automatic logic [63:0] hash_step(logic [63:0] h, logic [7:0] c);
    logic [127:0] acc;
    acc = {64'd0, h} * 128'd97;
    acc = acc % {64'd0, HASH_MOD};
    // A character below the offset contributes a negative term that wraps.
    acc = acc + {64'd0, HASH_MOD} + {120'd0, c} - {120'd0, CHAR_OFS};
    acc = acc % {64'd0, HASH_MOD};
    return acc[63:0];
  endfunction

  function automatic int locate_key(logic [63:0] k);
    for (int i = 0; i < live_entries; i++)
      if (key_mirror[i] == k) return i;
    return -1;
  endfunction

  // Predict one result and update the shadow state for an accepted beat.
  function automatic out_beat_t predict_table_op(in_beat_t b);
    out_beat_t r;
    logic [63:0] used;
    int idx;
    r.status = ST_DONE;
    r.found_handler = '0;
    used = name_hash;
    r.found_hash = used;
    case (b.opcode)
      OP_CHAR: begin
        name_hash = hash_step(name_hash, b.key_char);
        r.found_hash = name_hash;
      end
      OP_INSERT: begin
        name_hash = '0;
        if (b.handler_id == 0) begin
          r.status = ST_IGNORED;
        end else begin
          idx = locate_key(used);
          if (idx >= 0) begin
            hid_mirror[idx] = b.handler_id;
          end else if (live_entries >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            key_mirror[live_entries] = used;
            hid_mirror[live_entries] = b.handler_id;
            live_entries++;
          end
        end
      end
      OP_DELETE: begin
        name_hash = '0;
        idx = locate_key(used);
        if (idx < 0) begin
          r.status = ST_NOTFND;
        end else begin
          for (int i = idx; i + 1 < live_entries; i++) begin
            key_mirror[i] = key_mirror[i+1];
            hid_mirror[i] = hid_mirror[i+1];
          end
          live_entries--;
        end
      end
      OP_LKNAME, OP_LKHASH: begin
        if (b.opcode == OP_LKNAME) begin
          name_hash = '0;
          idx = locate_key(used);
        end else begin
          idx = locate_key(b.given_hash);
        end
        if (idx < 0) r.status = ST_NOTFND;
        else r.found_handler = hid_mirror[idx];
      end
      OP_FINDH: begin
        r.found_hash = ALL_ONES;
        if (b.handler_id == 0) begin
          r.status = ST_IGNORED;
        end else begin
          r.status = ST_NOTFND;
          for (int i = 0; i < live_entries; i++) begin
            if (hid_mirror[i] == b.handler_id) begin
              r.status = ST_DONE;
              r.found_handler = b.handler_id;
              r.found_hash = key_mirror[i];
              break;
            end
          end
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    return r;
  endfunction

  // Result checker: the block's strobe cannot be held off, so every cycle
  // with out_valid high carries one beat that must match the oldest prediction.
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status=%0d handler=%0h hash=%0h",
               out_beat.status, out_beat.found_handler, out_beat.found_hash);
        any_failure = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (out_beat.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_beat.status);
          any_failure = 1'b1;
        end
        if (out_beat.found_handler !== want.found_handler) begin
          $error("found_handler: expected %0h, got %0h",
                 want.found_handler, out_beat.found_handler);
          any_failure = 1'b1;
        end
        if (out_beat.found_hash !== want.found_hash) begin
          $error("found_hash: expected %0h, got %0h",
                 want.found_hash, out_beat.found_hash);
          any_failure = 1'b1;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Directed stimulus. A row with check_fixed set also carries a result
  // that is plain from the spec; the predictor must agree with it.
  typedef struct {
    in_beat_t  beat;
    bit        check_fixed;
    out_beat_t fixed;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic in_beat_t mk_beat(op_t op, logic [7:0] ch, logic [63:0] gh,
                                       logic [15:0] hid);
    in_beat_t b;
    b.opcode = op;
    b.key_char = ch;
    b.given_hash = gh;
    b.handler_id = hid;
    return b;
  endfunction

  function automatic void add_row(in_beat_t b, bit chk = 0,
                                  logic [1:0] st = 0, logic [15:0] fh = 0,
                                  logic [63:0] fhash = 0);
    stim_row_t row;
    row.beat = b;
    row.check_fixed = chk;
    row.fixed.status = st;
    row.fixed.found_handler = fh;
    row.fixed.found_hash = fhash;
    directed_rows.push_back(row);
  endfunction

  // Names to draw from, so that random traffic keeps hitting stored entries.
  logic [7:0] name_bank [8][4];
  int         name_len [8];
  bit         idle_enabled;

  // Random pause before a beat; skipped during the quiet stretch.
  task automatic maybe_idle();
    while (idle_enabled && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Present one beat and hold it until the block takes it.
  task automatic send_beat(in_beat_t b);
    maybe_idle();
    start   <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_table_op(b));
  endtask

  task automatic send_name(int n);
    for (int i = 0; i < name_len[n]; i++)
      send_beat(mk_beat(OP_CHAR, name_bank[n][i], '0, '0));
  endtask

  function automatic in_beat_t rand_beat(op_t op);
    in_beat_t b;
    b.opcode = op;
    b.key_char = 8'($urandom_range(255));
    b.given_hash = {$urandom(), $urandom()};
    b.handler_id = 16'($urandom_range(65535));
    return b;
  endfunction

  initial begin
    out_beat_t guess;
    int pick;
    int wait_cycles;
    start = 1'b0;
    in_beat = '0;
    rst_n = 1'b0;
    name_hash = '0;
    live_entries = 0;
    any_failure = 1'b0;
    cycle_count = 0;
    idle_enabled = 1'b1;
    for (int n = 0; n < 8; n++) begin
      name_len[n] = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) name_bank[n][i] = 8'($urandom_range(32, 126));
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Right after reset the table is empty and the running hash is zero.
    add_row(mk_beat(OP_LKNAME, 8'd0, '0, '0), 1, ST_NOTFND, 16'd0, 64'd0);
    add_row(mk_beat(OP_LKHASH, 8'd0, ALL_ONES, '0), 1, ST_NOTFND, 16'd0, 64'd0);
    add_row(mk_beat(OP_FINDH, 8'd0, '0, 16'd0), 1, ST_IGNORED, 16'd0, ALL_ONES);
    add_row(mk_beat(OP_FINDH, 8'd0, '0, 16'hFFFF), 1, ST_NOTFND, 16'd0, ALL_ONES);
    add_row(mk_beat(OP_DELETE, 8'd0, '0, '0), 1, ST_NOTFND, 16'd0, 64'd0);
    add_row(mk_beat(op_t'(3'd6), 8'hFF, ALL_ONES, 16'hFFFF), 1, ST_IGNORED, 0, 0);
    add_row(mk_beat(op_t'(3'd7), 8'h00, '0, 16'h0), 1, ST_IGNORED, 0, 0);
    // From a zero hash, a single character gives c - 31.
    add_row(mk_beat(OP_CHAR, 8'd255, '0, '0), 1, ST_DONE, 0, 64'd224);
    add_row(mk_beat(OP_INSERT, 8'd0, '0, 16'hFFFF), 1, ST_DONE, 0, 64'd224);
    add_row(mk_beat(OP_FINDH, 8'd0, '0, 16'hFFFF), 1, ST_DONE, 16'hFFFF, 64'd224);
    add_row(mk_beat(OP_LKHASH, 8'd0, 64'd224, '0), 1, ST_DONE, 16'hFFFF, 64'd0);
    // Characters below the offset wrap within the modulus.
    add_row(mk_beat(OP_CHAR, 8'd0, '0, '0), 1, ST_DONE, 0, HASH_MOD - 64'd31);
    add_row(mk_beat(OP_CHAR, 8'd30, '0, '0));
    add_row(mk_beat(OP_CHAR, 8'd31, '0, '0));
    add_row(mk_beat(OP_INSERT, 8'd0, '0, 16'd0));  // handler none is ignored
    add_row(mk_beat(OP_CHAR, 8'd32, '0, '0));
    add_row(mk_beat(OP_INSERT, 8'd0, '0, 16'd1));
    add_row(mk_beat(OP_CHAR, 8'd32, '0, '0));
    add_row(mk_beat(OP_INSERT, 8'd0, '0, 16'h5A5A));  // update in place
    add_row(mk_beat(OP_CHAR, 8'd32, '0, '0));
    add_row(mk_beat(OP_LKNAME, 8'd0, '0, '0));
    add_row(mk_beat(OP_CHAR, 8'd255, '0, '0));
    add_row(mk_beat(OP_DELETE, 8'd0, '0, '0));
    add_row(mk_beat(OP_FINDH, 8'd0, '0, 16'hFFFF), 1, ST_NOTFND, 16'd0, ALL_ONES);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].check_fixed) begin
        // Predict the result, which also advances the shadow state, and hold it to the fixed one.
        guess = predict_table_op(directed_rows[i].beat);
        if (guess != directed_rows[i].fixed) begin
          $error("directed row %0d: predictor disagrees with the fixed result", i);
          any_failure = 1'b1;
        end
        pending_results.push_back(guess);
        maybe_idle();
        start   <= 1'b1;
        in_beat <= directed_rows[i].beat;
        @(posedge clk);
        while (busy) @(posedge clk);
      end else begin
        send_beat(directed_rows[i].beat);
      end
    end

    // Fill the table to capacity with distinct two-character names, then
    // probe the table-full case on a fresh name.
    for (int c = 33; c < 255 && live_entries < TABLE_DEPTH; c++) begin
      send_beat(mk_beat(OP_CHAR, 8'(c), '0, '0));
      send_beat(mk_beat(OP_CHAR, 8'd77, '0, '0));
      send_beat(mk_beat(OP_INSERT, 8'd0, '0, 16'(c * 131 + 1)));
    end
    send_beat(mk_beat(OP_CHAR, 8'd200, '0, '0));
    send_beat(mk_beat(OP_CHAR, 8'd200, '0, '0));
    send_beat(mk_beat(OP_CHAR, 8'd200, '0, '0));
    send_beat(mk_beat(OP_INSERT, 8'd0, '0, 16'h1234));
    // Delete an early entry so a long shift happens.
    send_beat(mk_beat(OP_CHAR, 8'd33, '0, '0));
    send_beat(mk_beat(OP_CHAR, 8'd77, '0, '0));
    send_beat(mk_beat(OP_DELETE, 8'd0, '0, '0));

    // Random part: mostly named operations built from the name bank.
    for (int k = 0; k < 85; k++) begin
      idle_enabled = !(k >= 30 && k < 55);
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_name($urandom_range(7));
        case ($urandom_range(3))
          0, 1: send_beat(mk_beat(OP_INSERT, 8'd0, '0,
                                  ($urandom_range(9) == 0) ? 16'd0
                                                           : 16'($urandom_range(65535))));
          2: send_beat(mk_beat(OP_DELETE, 8'd0, '0, '0));
          default: send_beat(mk_beat(OP_LKNAME, 8'd0, '0, '0));
        endcase
      end else if (pick < 80) begin
        send_beat(mk_beat(OP_LKHASH, 8'd0,
                          (live_entries > 0 && $urandom_range(1))
                            ? key_mirror[$urandom_range(live_entries - 1)]
                            : {$urandom(), $urandom()}, '0));
      end else if (pick < 90) begin
        send_beat(mk_beat(OP_FINDH, 8'd0, '0,
                          (live_entries > 0 && $urandom_range(1))
                            ? hid_mirror[$urandom_range(live_entries - 1)]
                            : 16'($urandom_range(65535))));
      end else begin
        send_beat(rand_beat(op_t'(3'($urandom_range(7)))));
      end
    end
    start <= 1'b0;

    // Drain, then allow the longest operation time for stray beats.
    while (pending_results.size() != 0) @(posedge clk);
    wait_cycles = 2 * TABLE_DEPTH + 10;
    repeat (wait_cycles) @(posedge clk);

    if (!any_failure && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
